// File: hw/rtl/hnfl_pkg.sv
// Package with the shared constants, types and helper functions of the name frequency leader.
`default_nettype none

package hnfl_pkg;

	// Default size of the slot table, a power of two.
	localparam int unsigned DEF_TABLE_DEPTH = 1024;

	// Fixed field widths and name handling.
	localparam int unsigned NAME_W      = 64;
	localparam int unsigned NAME_BYTES  = 8;
	localparam int unsigned LEN_W       = 4;
	localparam int unsigned COUNT_WIDTH = 20;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Hash constants: h = h*HASH_MULT + byte, bucket from h mod HASH_MOD.
	localparam int unsigned HASH_MULT = 131;
	localparam int unsigned HASH_MOD  = 10007;
	localparam int unsigned HREM_W    = $clog2(HASH_MOD);
	localparam int unsigned HSUM_W    = $clog2(HASH_MOD * HASH_MULT + 256);
	localparam int unsigned RED_STEPS = $clog2(HASH_MULT + 2);

	typedef struct packed {
		logic [NAME_W-1:0] key;
		logic [LEN_W-1:0]  len;
	} canon_t;

	typedef struct packed {
		logic              start;
		logic [NAME_W-1:0] key;
		logic [LEN_W-1:0]  len;
	} hash_req_t;

	typedef struct packed {
		logic              done;
		logic [HREM_W-1:0] bucket;
	} hash_rsp_t;

	typedef struct packed {
		logic                   valid;
		logic [NAME_W-1:0]      key;
		logic [COUNT_WIDTH-1:0] count;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_CHECK,
		ST_RESULT
	} state_t;

	// Keep the bytes before the first zero byte and below NAME_BYTES; count them.
	function automatic canon_t canon_name(logic [NAME_W-1:0] raw);
		canon_t c;
		logic   alive;
		c.key = '0;
		c.len = '0;
		alive = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (i < NAME_BYTES && alive && raw[8*i +: 8] != 8'h00) begin
				c.key[8*i +: 8] = raw[8*i +: 8];
				c.len = c.len + LEN_W'(1);
			end else begin
				alive = 1'b0;
			end
		end
		return c;
	endfunction

	// Reduce a partial hash below HASH_MOD by restoring subtraction of shifted moduli.
	function automatic logic [HREM_W-1:0] hash_reduce(logic [HSUM_W-1:0] t);
		logic [HSUM_W-1:0] rem;
		logic [HSUM_W-1:0] sub;
		rem = t;
		for (int i = RED_STEPS - 1; i >= 0; i--) begin
			sub = HSUM_W'(HASH_MOD) << i;
			if (rem >= sub) begin
				rem = rem - sub;
			end
		end
		return rem[HREM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hnfl_if.sv
// Handshake interfaces for the name input channel and the result output channel.
`default_nettype none

interface hnfl_name_if;
	logic                          valid;
	logic                          ready;
	logic [hnfl_pkg::NAME_W-1:0]   name_bytes;

	modport source (output valid, output name_bytes, input ready);
	modport sink   (input valid, input name_bytes, output ready);
endinterface

interface hnfl_result_if;
	logic                              valid;
	logic                              ready;
	logic [hnfl_pkg::NAME_W-1:0]       leader_name;
	logic [hnfl_pkg::COUNT_WIDTH-1:0]  leader_count;
	logic [hnfl_pkg::COUNT_WIDTH-1:0]  item_count;
	logic                              table_full;

	modport source (output valid, output leader_name, output leader_count,
		output item_count, output table_full, input ready);
	modport sink   (input valid, input leader_name, input leader_count,
		input item_count, input table_full, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hnfl_hash.sv
// Byte-serial polynomial hash unit that leaves the hash modulo the bucket prime.
`default_nettype none

module hnfl_hash (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hnfl_pkg::hash_req_t  req,
	output hnfl_pkg::hash_rsp_t  rsp
);
	import hnfl_pkg::*;

	logic              busy_q;
	logic              red_phase_q;
	logic              done_q;
	logic [NAME_W-1:0] key_q;
	logic [LEN_W-1:0]  left_q;
	logic [HREM_W-1:0] rem_q;
	logic [HSUM_W-1:0] sum_q;
	logic [HSUM_W-1:0] sum_d;

	// Multiply-add step: the running remainder times the multiplier plus the next byte.
	assign sum_d = HSUM_W'(rem_q) * HSUM_W'(HASH_MULT) + HSUM_W'(key_q[7:0]);

	// Sequencing: each byte goes through a multiply-add step and then a reduction step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			red_phase_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (req.start) begin
				busy_q      <= (req.len != '0);
				red_phase_q <= 1'b0;
				done_q      <= (req.len == '0);
			end else if (busy_q) begin
				red_phase_q <= !red_phase_q;
				if (red_phase_q && left_q == LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the shared multiply-add and reduction unit.
	always_ff @(posedge clk) begin
		if (req.start) begin
			key_q  <= req.key;
			left_q <= req.len;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!red_phase_q) begin
				sum_q <= sum_d;
				key_q <= key_q >> 8;
			end else begin
				rem_q  <= hash_reduce(sum_q);
				left_q <= left_q - LEN_W'(1);
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.bucket = rem_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < HREM_W'(HASH_MOD))
		else $error("hash remainder left its range");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("hash done held for more than one cycle");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("hash restarted while busy");

endmodule

`default_nettype wire

// File: hw/rtl/hashed_name_frequency_leader.sv
// Top level of the name frequency counter with a running leader.
// Each beat on names carries one name of up to eight bytes. The block hashes it byte by byte
// (a multiply-add and a modular reduction in one shared unit), then probes the slot table
// linearly, one slot per cycle, through a table RAM with one write port, one read port and
// registered read data. names is not ready while an item is in progress. A finished result
// sits in an output register, so the next name is taken while that result waits. After reset
// the block sweeps every slot of the table to clear it before it takes the first name.
`default_nettype none

module hashed_name_frequency_leader #(
	parameter int unsigned TABLE_DEPTH = hnfl_pkg::DEF_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	hnfl_name_if.sink    names,
	hnfl_result_if.source results
);
	import hnfl_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	state_t state_q;
	state_t state_d;

	logic [IDX_W-1:0]       clr_idx_q;
	logic [NAME_W-1:0]      key_q;
	logic [IDX_W-1:0]       pos_q;
	logic [IDX_W-1:0]       probes_q;
	entry_t                 rd_q;
	logic [COUNT_WIDTH-1:0] item_cnt_q;
	logic                   full_q;
	logic                   found_q;
	logic [NAME_W-1:0]      best_name_q;
	logic [COUNT_WIDTH-1:0] best_count_q;

	logic                   out_valid_q;
	logic [NAME_W-1:0]      out_name_q;
	logic [COUNT_WIDTH-1:0] out_lcount_q;
	logic [COUNT_WIDTH-1:0] out_icount_q;
	logic                   out_full_q;

	entry_t mem [TABLE_DEPTH];

	logic                    in_ready;
	logic                    accept;
	canon_t                  canon;
	hash_req_t               hash_req;
	hash_rsp_t               hash_rsp;
	logic [IDX_W+HREM_W-1:0] bucket_ext;
	logic [IDX_W-1:0]        bucket_pos;
	logic                    slot_free;
	logic                    slot_hit;
	logic                    last_probe;
	logic [IDX_W-1:0]        next_pos;
	logic [COUNT_WIDTH-1:0]  bumped;
	logic                    out_free;
	logic                    take_lead;
	logic                    mem_we;
	logic [IDX_W-1:0]        wr_addr;
	entry_t                  wr_data;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;

	// Input handshake and name canonicalization.
	assign accept       = names.valid && in_ready;
	assign names.ready  = in_ready;
	assign canon        = canon_name(names.name_bytes);
	assign hash_req     = '{start: accept, key: canon.key, len: canon.len};

	hnfl_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hash_req),
		.rsp    (hash_rsp)
	);

	// Probe decisions on the slot read back from the table.
	assign bucket_ext = {{IDX_W{1'b0}}, hash_rsp.bucket};
	assign bucket_pos = bucket_ext[IDX_W-1:0];
	assign slot_free  = !rd_q.valid;
	assign slot_hit   = rd_q.valid && (rd_q.key == key_q);
	assign last_probe = (probes_q == LAST_IDX);
	assign next_pos   = pos_q + IDX_W'(1);
	assign bumped     = (rd_q.count == COUNT_MAX) ? COUNT_MAX : rd_q.count + COUNT_WIDTH'(1);
	assign out_free   = !out_valid_q || results.ready;
	assign take_lead  = found_q && (item_cnt_q > best_count_q);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_rsp.done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (slot_free || slot_hit || last_probe) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer: table port controls and input ready.
	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		wr_addr  = pos_q;
		wr_data  = '{valid: 1'b1, key: key_q, count: COUNT_WIDTH'(1)};
		rd_en    = 1'b0;
		rd_addr  = pos_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_HASH: begin
				rd_en   = hash_rsp.done;
				rd_addr = bucket_pos;
			end
			ST_CHECK: begin
				if (slot_free) begin
					mem_we = 1'b1;
				end else if (slot_hit) begin
					mem_we        = 1'b1;
					wr_data.count = bumped;
				end else if (!last_probe) begin
					rd_en   = 1'b1;
					rd_addr = next_pos;
				end
			end
			ST_RESULT: begin
				in_ready = 1'b0;
			end
			default: in_ready = 1'b0;
		endcase
	end

	// Control state, clearing sweep, leader and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
			best_name_q  <= '0;
			best_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
				if (take_lead) begin
					best_name_q  <= key_q;
					best_count_q <= item_cnt_q;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath: key, probe position and the outcome of the lookup.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= canon.key;
		end
		if (state_q == ST_HASH && hash_rsp.done) begin
			pos_q    <= bucket_pos;
			probes_q <= '0;
		end
		if (state_q == ST_CHECK) begin
			if (slot_free) begin
				item_cnt_q <= COUNT_WIDTH'(1);
				full_q     <= 1'b0;
				found_q    <= 1'b1;
			end else if (slot_hit) begin
				item_cnt_q <= bumped;
				full_q     <= 1'b0;
				found_q    <= 1'b1;
			end else if (last_probe) begin
				item_cnt_q <= '0;
				full_q     <= 1'b1;
				found_q    <= 1'b0;
			end else begin
				pos_q    <= next_pos;
				probes_q <= probes_q + IDX_W'(1);
			end
		end
		if (state_q == ST_RESULT && out_free) begin
			out_name_q   <= take_lead ? key_q : best_name_q;
			out_lcount_q <= take_lead ? item_cnt_q : best_count_q;
			out_icount_q <= item_cnt_q;
			out_full_q   <= full_q;
		end
	end

	// Slot table RAM: one write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Result beat.
	assign results.valid        = out_valid_q;
	assign results.leader_name  = out_name_q;
	assign results.leader_count = out_lcount_q;
	assign results.item_count   = out_icount_q;
	assign results.table_full   = out_full_q;

	a_leader_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		best_count_q >= $past(best_count_q))
		else $error("leader count decreased");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.table_full) |-> results.item_count == '0)
		else $error("dropped name reported a nonzero count");

	a_item_le_leader: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.table_full) |-> results.item_count <= results.leader_count)
		else $error("item count exceeds leader count");

	a_hash_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_rsp.done |-> state_q == ST_HASH)
		else $error("hash finished outside the hash state");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the name frequency leader, with random traffic and a running predictor.
`timescale 1ns / 1ps

module testbench;
	import hnfl_pkg::*;

	localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int unsigned POOL_SIZE   = 48;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned LONG_GAP    = 60;
	// Worst case per name: a full probe of the table, the byte-serial hash and both sides idling.
	localparam int unsigned CYCLE_LIMIT =
		3 * (TABLE_DEPTH + 2000 * (TABLE_DEPTH + 2 * NAME_BYTES + 4 + 2 * LONG_GAP)
		+ 2 * HOLD_CYCLES);

	typedef struct {
		bit [NAME_W-1:0]      leader_name;
		bit [COUNT_WIDTH-1:0] leader_count;
		bit [COUNT_WIDTH-1:0] item_count;
		bit                   table_full;
	} tally_t;

	// One entry of the send list: either a name to offer or a wait for all results.
	typedef struct {
		bit              drain;
		bit [NAME_W-1:0] raw;
	} offer_t;

	logic clk;
	logic arst_n;

	hnfl_name_if   name_bus();
	hnfl_result_if result_bus();

	hashed_name_frequency_leader #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.names(name_bus),
		.results(result_bus)
	);

	// Predictor copy of the slot table and the leader.
	bit                   occupied[TABLE_DEPTH];
	bit [NAME_W-1:0]      stored_name[TABLE_DEPTH];
	bit [COUNT_WIDTH-1:0] stored_count[TABLE_DEPTH];
	bit [NAME_W-1:0]      top_name;
	bit [COUNT_WIDTH-1:0] top_count;
	int unsigned          filled_slots;

	offer_t      name_queue[$];
	tally_t      tally_queue[$];
	bit          seen_keys[bit [NAME_W-1:0]];
	bit [NAME_W-1:0] known_keys[$];
	bit [NAME_W-1:0] pool[POOL_SIZE];

	int unsigned mismatches    = 0;
	int unsigned names_taken   = 0;
	int unsigned results_seen  = 0;
	int unsigned dropped_names = 0;
	int unsigned leader_moves  = 0;
	int unsigned cycles        = 0;
	int unsigned send_gap      = 0;
	int unsigned stall_left    = 0;
	int unsigned hold_left     = 0;
	int unsigned holds_done    = 0;
	bit          send_calm     = 0;
	bit          take_calm     = 0;
	bit          in_taken      = 0;

	// Keep the bytes before the first zero byte and hash them with the polynomial hash.
	function automatic void trim_name(input bit [NAME_W-1:0] raw, output bit [NAME_W-1:0] key,
		output bit [63:0] h);
		bit [7:0] b;
		key = '0;
		h = '0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			b = raw[8*i +: 8];
			if (b == 8'h00) break;
			key[8*i +: 8] = b;
			h = h * 64'(HASH_MULT) + 64'(b);
		end
	endfunction

	function automatic int unsigned bucket_of(bit [NAME_W-1:0] raw);
		bit [NAME_W-1:0] key;
		bit [63:0]       h;
		trim_name(raw, key, h);
		return 32'(h % 64'(HASH_MOD)) & (TABLE_DEPTH - 1);
	endfunction

	// Count one name in the table and return the result beat it should produce.
	function automatic tally_t count_name(bit [NAME_W-1:0] raw);
		bit [NAME_W-1:0] key;
		bit [63:0]       h;
		int unsigned     pos;
		bit              placed;
		tally_t          r;
		trim_name(raw, key, h);
		pos = bucket_of(raw);
		placed = 1'b0;
		r.item_count = '0;
		r.table_full = 1'b0;
		for (int n = 0; n < TABLE_DEPTH && !placed; n++) begin
			if (!occupied[pos]) begin
				occupied[pos] = 1'b1;
				stored_name[pos] = key;
				stored_count[pos] = COUNT_WIDTH'(1);
				filled_slots++;
				r.item_count = COUNT_WIDTH'(1);
				placed = 1'b1;
			end else if (stored_name[pos] == key) begin
				if (stored_count[pos] != COUNT_MAX) stored_count[pos]++;
				r.item_count = stored_count[pos];
				placed = 1'b1;
			end else begin
				pos = (pos + 1) & (TABLE_DEPTH - 1);
			end
		end
		if (!placed) begin
			r.table_full = 1'b1;
			dropped_names++;
		end else if (r.item_count > top_count) begin
			top_count = r.item_count;
			top_name = key;
			leader_moves++;
		end
		r.leader_name = top_name;
		r.leader_count = top_count;
		return r;
	endfunction

	// Random name of the given length with nonzero bytes.
	function automatic bit [NAME_W-1:0] random_key(int unsigned len);
		bit [NAME_W-1:0] k;
		k = '0;
		for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
		return k;
	endfunction

	function automatic bit [NAME_W-1:0] fresh_key();
		bit [NAME_W-1:0] k;
		do k = random_key($urandom_range(1, 8)); while (seen_keys.exists(k));
		return k;
	endfunction

	function automatic bit [NAME_W-1:0] key_in_bucket(int unsigned target);
		bit [NAME_W-1:0] k;
		do k = random_key($urandom_range(1, 8));
		while (bucket_of(k) != target || seen_keys.exists(k));
		return k;
	endfunction

	// Half the time fill the bytes after the terminator with junk the block must ignore.
	function automatic bit [NAME_W-1:0] dress(bit [NAME_W-1:0] key);
		bit [NAME_W-1:0] raw;
		int unsigned     len;
		raw = key;
		len = 0;
		while (len < 8 && key[8*len +: 8] != 8'h00) len++;
		if (len < 7 && $urandom_range(0, 1) == 1) begin
			for (int i = len + 1; i < 8; i++) raw[8*i +: 8] = 8'($urandom);
		end
		return raw;
	endfunction

	function automatic void queue_name(bit [NAME_W-1:0] raw);
		bit [NAME_W-1:0] key;
		bit [63:0]       h;
		offer_t          o;
		trim_name(raw, key, h);
		if (!seen_keys.exists(key)) begin
			seen_keys[key] = 1'b1;
			known_keys.push_back(key);
		end
		o.drain = 1'b0;
		o.raw = raw;
		name_queue.push_back(o);
	endfunction

	function automatic void queue_drain();
		offer_t o;
		o.drain = 1'b1;
		o.raw = '0;
		name_queue.push_back(o);
	endfunction

	// Mostly short gaps, a few long ones, none at all during a calm stretch.
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, LONG_GAP);
	endfunction

	function automatic void flag_mismatch(string field, bit [63:0] want, logic [63:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		mismatches++;
	endfunction

	always #6 clk = ~clk;

	// Driver: offers one name beat at a time on the falling edge.
	always @(negedge clk) begin
		offer_t next;
		if (!arst_n) begin
			name_bus.valid <= 1'b0;
			name_bus.name_bytes <= '0;
		end else if (name_bus.valid && !in_taken) begin
			// The current beat has not been taken yet, so it stays on the bus.
		end else if (send_gap != 0) begin
			name_bus.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (name_queue.size() != 0 && name_queue[0].drain) begin
			name_bus.valid <= 1'b0;
			if (tally_queue.size() == 0) void'(name_queue.pop_front());
		end else if (name_queue.size() != 0) begin
			next = name_queue.pop_front();
			name_bus.valid <= 1'b1;
			name_bus.name_bytes <= next.raw;
			send_gap <= pick_gap(send_calm);
			if ($urandom_range(0, 99) == 0) send_calm <= !send_calm;
		end else begin
			name_bus.valid <= 1'b0;
		end
	end

	// Receiver: random back-pressure, plus the long holds counted below.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (hold_left != 0) begin
			result_bus.ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_bus.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_bus.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(take_calm);
			if ($urandom_range(0, 199) == 0) take_calm <= !take_calm;
		end
	end

	// Two long holds on the result side while names keep coming, to back the block up.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && results_seen >= 120)
			|| (holds_done == 1 && results_seen >= 1100)) begin
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// Monitor: checks each result beat, then predicts for each accepted name beat.
	always @(posedge clk) begin
		tally_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (tally_queue.size() == 0) begin
					$display("%0t: result beat with no name outstanding, leader %h count %0d",
						$time, result_bus.leader_name, result_bus.leader_count);
					mismatches++;
				end else begin
					want = tally_queue.pop_front();
					if (result_bus.leader_name !== want.leader_name)
						flag_mismatch("leader_name", want.leader_name, result_bus.leader_name);
					if (result_bus.leader_count !== want.leader_count)
						flag_mismatch("leader_count", 64'(want.leader_count),
							64'(result_bus.leader_count));
					if (result_bus.item_count !== want.item_count)
						flag_mismatch("item_count", 64'(want.item_count),
							64'(result_bus.item_count));
					if (result_bus.table_full !== want.table_full)
						flag_mismatch("table_full", 64'(want.table_full),
							64'(result_bus.table_full));
				end
			end
			if (name_bus.valid && name_bus.ready) begin
				names_taken++;
				tally_queue.push_back(count_name(name_bus.name_bytes));
			end
			in_taken <= name_bus.valid && name_bus.ready;
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, tally_queue.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit [NAME_W-1:0] first_key;
		bit [NAME_W-1:0] second_key;
		bit [NAME_W-1:0] third_key;
		bit [NAME_W-1:0] edge_key;
		bit [NAME_W-1:0] wrap_key;
		clk = 1'b0;
		arst_n = 1'b0;
		name_bus.valid = 1'b0;
		name_bus.name_bytes = '0;
		result_bus.ready = 1'b0;
		top_name = '0;
		top_count = '0;
		filled_slots = 0;

		// Directed: empty name, junk after a leading zero, high bytes, ties and the leader.
		queue_name(64'h0000_0000_0000_0000);
		queue_name(64'hFFFF_FFFF_FFFF_FF00);
		queue_name(64'hFFFF_FFFF_FFFF_FFFF);
		queue_name(64'h0000_0000_0000_0001);
		queue_name(64'h8000_0000_0000_0041);
		queue_name(64'h0000_0000_0000_0041);
		queue_name(64'h7F80_0102_0304_05FF);
		queue_name(64'h0000_0000_0000_0041);
		queue_name(64'h0102_0304_0506_0700);

		// Directed: three names in one bucket, so hits and inserts probe past others.
		first_key = key_in_bucket($urandom_range(1, TABLE_DEPTH - 2));
		queue_name(first_key);
		second_key = key_in_bucket(bucket_of(first_key));
		queue_name(dress(second_key));
		third_key = key_in_bucket(bucket_of(first_key));
		queue_name(third_key);
		queue_name(dress(third_key));
		queue_name(second_key);

		// Directed: two names in the last bucket, so the probe wraps to the start.
		edge_key = key_in_bucket(TABLE_DEPTH - 1);
		queue_name(edge_key);
		wrap_key = key_in_bucket(TABLE_DEPTH - 1);
		queue_name(wrap_key);
		queue_name(dress(wrap_key));
		queue_name(edge_key);
		queue_drain();

		// Random: a skewed pool of names for hits, leader changes and ties, with some noise.
		for (int i = 0; i < POOL_SIZE; i++) pool[i] = fresh_key();
		for (int i = 0; i < 600; i++) begin
			if ($urandom_range(0, 9) == 0)
				queue_name({$urandom, $urandom});
			else
				queue_name(dress(pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))]));
			if (i == 300) queue_drain();
		end
		queue_drain();

		// Random: new names until the table is full and some get turned away.
		while (seen_keys.num() < TABLE_DEPTH + 40) begin
			if ($urandom_range(0, 5) == 0)
				queue_name(dress(pool[$urandom_range(0, POOL_SIZE - 1)]));
			else
				queue_name(dress(fresh_key()));
		end

		// Random: a full table, revisiting stored names and offering new ones.
		for (int i = 0; i < 150; i++) begin
			if ($urandom_range(0, 2) == 0)
				queue_name(dress(fresh_key()));
			else
				queue_name(dress(known_keys[$urandom_range(0, known_keys.size() - 1)]));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every name to be taken and every result to come back, then a quiet spell.
		while (name_queue.size() != 0 || name_bus.valid || tally_queue.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 4 * NAME_BYTES + 16) @(posedge clk);

		$display("Run covered %0d names and %0d results; %0d table slots filled.",
			names_taken, results_seen, filled_slots);
		$display("The leader changed %0d times; %0d names were turned away by a full table.",
			leader_moves, dropped_names);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
